@@ hw/rtl/fcms_pkg.sv @@
// ----------------------------------------------------------------------------
// fcms_pkg
// Shared types and constants of the fixed capacity multiset store: request
// codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package fcms_pkg;

  // default geometry
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned ItemWidthDef = 32;

  // fixed port widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned ItemPortW = 32;
  localparam int unsigned FieldW   = 5;

  // request codes
  typedef enum logic [OpW-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_COUNT    = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LAST = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } st_e;

  // one result record
  typedef struct packed {
    logic              ok;
    logic [FieldW-1:0] frequency;
    logic [FieldW-1:0] size;
    logic              empty_res;
    logic              full_res;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/fcms_mem.sv @@
// ----------------------------------------------------------------------------
// fcms_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcms_mem import fcms_pkg::*; #(
  parameter int unsigned DEPTH = CapacityDef,
  parameter int unsigned WIDTH = ItemWidthDef
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fcms_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcms_ctrl
// Request sequencer: holds the fill count, scans the entry memory with one
// read per cycle, and does the write-back for add and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module fcms_ctrl import fcms_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned ITEM_WIDTH = ItemWidthDef,
  localparam int unsigned CntW  = $clog2(CAPACITY + 1),
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request side
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [OpW-1:0]        op_i,
  input  wire logic [ItemPortW-1:0]  item_i,
  // memory port
  output logic                       mem_we_o,
  output logic      [AddrW-1:0]      mem_waddr_o,
  output logic      [ITEM_WIDTH-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic      [AddrW-1:0]      mem_raddr_o,
  input  wire logic [ITEM_WIDTH-1:0] mem_rdata_i,
  // result side
  output logic                       res_valid_o,
  input  wire logic                  res_free_i,
  output res_t                       res_o
);

  st_e                   st_q, st_d;
  logic [OpW-1:0]        op_q, op_d;
  logic [ITEM_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       iss_q, iss_d;
  logic                  pend_q, pend_d;
  logic [AddrW-1:0]      pidx_q, pidx_d;
  logic [ITEM_WIDTH-1:0] last_q, last_d;
  logic                  last_pend_q, last_pend_d;
  logic [AddrW-1:0]      hit_q, hit_d;
  logic                  found_q, found_d;
  logic [CntW-1:0]       freq_q, freq_d;

  logic [ITEM_WIDTH+ItemPortW-1:0] item_ext;
  logic [CntW-1:0]       last_idx;
  logic [CntW-1:0]       cnt_next;
  logic [CntW+FieldW-1:0] size_ext;
  logic [CntW+FieldW-1:0] freq_ext;
  logic                  is_full;
  logic                  is_empty;
  logic                  match;
  logic                  issue;
  logic                  finish;

  // request item limited to the entry width
  assign item_ext = {{ITEM_WIDTH{1'b0}}, item_i};

  assign last_idx = cnt_q - 1'b1;
  assign is_full  = (cnt_q == CntW'(CAPACITY));
  assign is_empty = (cnt_q == '0);
  assign match    = pend_q && (mem_rdata_i == key_q);
  assign issue    = (st_q == ST_SCAN) && (iss_q != cnt_q);
  assign finish   = (st_q == ST_DONE) && res_free_i;

  // fill count after the current request
  always_comb begin
    cnt_next = cnt_q;
    case (op_q)
      OP_ADD: begin
        if (!is_full) begin
          cnt_next = cnt_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found_q) begin
          cnt_next = cnt_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        cnt_next = cnt_q;
      end
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_REMOVE: st_d = is_empty ? ST_DONE : ST_LAST;
            OP_CONTAINS,
            OP_COUNT:  st_d = is_empty ? ST_DONE : ST_SCAN;
            default:   st_d = ST_DONE;
          endcase
        end
      end
      ST_LAST: begin
        st_d = ST_SCAN;
      end
      ST_SCAN: begin
        if ((match && (op_q == OP_REMOVE)) || (pend_q && (iss_q == cnt_q))) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // memory accesses and result
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = iss_q[AddrW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AddrW-1:0];
    mem_wdata_o = key_q;
    case (st_q)
      ST_LAST: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = last_idx[AddrW-1:0];
      end
      ST_SCAN: begin
        mem_re_o = issue;
      end
      ST_DONE: begin
        if (res_free_i && (op_q == OP_ADD) && !is_full) begin
          mem_we_o = 1'b1;
        end
        if (res_free_i && (op_q == OP_REMOVE) && found_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = hit_q;
          mem_wdata_o = last_q;
        end
      end
      default: begin
        mem_re_o = 1'b0;
      end
    endcase
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign res_valid_o = (st_q == ST_DONE);

  // status fields are the low bits of the counts
  assign size_ext = {{FieldW{1'b0}}, cnt_next};
  assign freq_ext = {{FieldW{1'b0}}, freq_q};

  always_comb begin
    res_o.size      = size_ext[FieldW-1:0];
    res_o.empty_res = (cnt_next == '0);
    res_o.full_res  = (cnt_next == CntW'(CAPACITY));
    res_o.frequency = '0;
    res_o.ok        = 1'b0;
    case (op_q)
      OP_ADD:      res_o.ok = !is_full;
      OP_REMOVE:   res_o.ok = found_q;
      OP_CONTAINS: res_o.ok = found_q;
      OP_COUNT:    res_o.frequency = freq_ext[FieldW-1:0];
      OP_CLEAR:    res_o.ok = 1'b1;
      default:     res_o.ok = 1'b0;
    endcase
  end

  // scan bookkeeping
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    iss_d       = iss_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    last_d      = last_q;
    last_pend_d = last_pend_q;
    hit_d       = hit_q;
    found_d     = found_q;
    freq_d      = freq_q;
    cnt_d       = cnt_q;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d        = op_i;
          key_d       = item_ext[ITEM_WIDTH-1:0];
          iss_d       = '0;
          pend_d      = 1'b0;
          last_pend_d = 1'b0;
          found_d     = 1'b0;
          freq_d      = '0;
        end
      end
      ST_LAST: begin
        last_pend_d = 1'b1;
      end
      ST_SCAN: begin
        // capture the last entry for the remove move
        last_pend_d = 1'b0;
        if (last_pend_q) begin
          last_d = mem_rdata_i;
        end
        pend_d = issue;
        pidx_d = iss_q[AddrW-1:0];
        if (issue) begin
          iss_d = iss_q + 1'b1;
        end
        if (match) begin
          found_d = 1'b1;
          freq_d  = freq_q + 1'b1;
          if (!found_q) begin
            hit_d = pidx_q;
          end
        end
      end
      ST_DONE: begin
        if (finish) begin
          cnt_d = cnt_next;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      last_pend_q <= 1'b0;
      found_q     <= 1'b0;
      iss_q       <= '0;
      freq_q      <= '0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      last_pend_q <= last_pend_d;
      found_q     <= found_d;
      iss_q       <= iss_d;
      freq_q      <= freq_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    pidx_q <= pidx_d;
    last_q <= last_d;
    hit_q  <= hit_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/fixed_capacity_multiset_store.sv @@
// ----------------------------------------------------------------------------
// fixed_capacity_multiset_store
// Bounded unordered multiset of items with add, remove, contains, count and
// clear requests, each answered by one result with size, empty and full.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, clear and unused codes go straight
// to the result. On a non-empty store contains and count scan all N entries,
// and remove reads the last entry and then scans at most N entries, where N
// is the number of entries held: the entry memory has a single read port, so
// the scan reads one entry per cycle, and remove stops at the first match.
// The result sits in an output register, so the next request is taken the
// cycle after the result is produced, even while it is still stalled.
`default_nettype none

module fixed_capacity_multiset_store import fcms_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned ITEM_WIDTH = ItemWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [ItemPortW-1:0] item_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      ok_o,
  output logic      [FieldW-1:0]    frequency_o,
  output logic      [FieldW-1:0]    size_o,
  output logic                      empty_res_o,
  output logic                      full_res_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AddrW-1:0]      mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_free;
  res_t                  res;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q;

  // sequencer
  fcms_ctrl #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .item_i      (item_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_free_i  (res_free),
    .res_o       (res)
  );

  // entry storage
  fcms_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_q.ok;
  assign frequency_o = out_q.frequency;
  assign size_o      = out_q.size;
  assign empty_res_o = out_q.empty_res;
  assign full_res_o  = out_q.full_res;

endmodule

`default_nettype wire

@@ bench/fixed_capacity_multiset_store_test.sv @@
// ----------------------------------------------------------------------------
// fixed_capacity_multiset_store_test
// Self-checking bench for the bounded multiset store: directed requests on
// the empty and the full store, then random traffic under four mixes of
// sender idling and receiver stalling, each result checked against a bag
// tracked in the bench.
// ----------------------------------------------------------------------------
module fixed_capacity_multiset_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fcms_pkg::*;

  localparam int unsigned Capacity = CapacityDef;

  // request codes the block does not define
  localparam logic [OpW-1:0] OpSpareFirst = 3'd5;
  localparam logic [OpW-1:0] OpSpareLast  = 3'd7;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OpW-1:0]       op_i = '0;
  logic [ItemPortW-1:0] item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 ok_o;
  logic [FieldW-1:0]    frequency_o;
  logic [FieldW-1:0]    size_o;
  logic                 empty_res_o;
  logic                 full_res_o;

  fixed_capacity_multiset_store uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .item_i      (item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .frequency_o (frequency_o),
    .size_o      (size_o),
    .empty_res_o (empty_res_o),
    .full_res_o  (full_res_o)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bag contents as the bench sees them
  logic [ItemPortW-1:0] bag_entry [Capacity];
  int unsigned          bag_fill;

  // results still owed by the block, oldest first
  res_t pending_results [$];
  res_t got_res;

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned full_reached;
  int unsigned add_rejected;

  // small pool of values so that random requests hit stored items
  logic [ItemPortW-1:0] item_pool [4];

  // apply one request to the bag and return the result it should produce
  function automatic res_t bag_apply(input logic [OpW-1:0] op, input logic [ItemPortW-1:0] item);
    res_t        r;
    int unsigned hits;
    bit          found;
    r = '0;
    hits = 0;
    found = 1'b0;
    for (int k = 0; k < bag_fill; k++) begin
      if (bag_entry[k] == item) hits++;
    end
    case (op)
      OP_ADD: begin
        if (bag_fill < Capacity) begin
          bag_entry[bag_fill] = item;
          bag_fill++;
          r.ok = 1'b1;
          if (bag_fill == Capacity) full_reached++;
        end else begin
          add_rejected++;
        end
      end
      OP_REMOVE: begin
        // first match takes the last entry, count shrinks
        for (int k = 0; k < bag_fill; k++) begin
          if (!found && bag_entry[k] == item) begin
            bag_entry[k] = bag_entry[bag_fill - 1];
            found = 1'b1;
          end
        end
        if (found) begin
          bag_fill--;
          r.ok = 1'b1;
        end
      end
      OP_CONTAINS: r.ok = (hits != 0);
      OP_COUNT:    r.frequency = hits[FieldW-1:0];
      OP_CLEAR: begin
        bag_fill = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.size      = bag_fill[FieldW-1:0];
    r.empty_res = (bag_fill == 0);
    r.full_res  = (bag_fill == Capacity);
    return r;
  endfunction

  // send one request and wait for it to be taken
  task automatic send_request(input logic [OpW-1:0] op, input logic [ItemPortW-1:0] item);
    res_t exp_res;
    in_valid_i <= 1'b1;
    op_i       <= op;
    item_i     <= item;
    do @(posedge clk_i); while (in_stall_o);
    exp_res = bag_apply(op, item);
    pending_results = {pending_results, exp_res};
    requests_sent++;
    // random gap before the next request
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] expv, input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, actual %0d", field, expv, actv);
      mismatches++;
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        got_res = pending_results.pop_front();
        check_field("ok", 32'(got_res.ok), 32'(ok_o));
        check_field("frequency", 32'(got_res.frequency), 32'(frequency_o));
        check_field("size", 32'(got_res.size), 32'(size_o));
        check_field("empty_res", 32'(got_res.empty_res), 32'(empty_res_o));
        check_field("full_res", 32'(got_res.full_res), 32'(full_res_o));
        results_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_pressure(input int unsigned send_pct, input int unsigned stall_pct);
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
  endtask

  // every request type but add on an empty store
  task automatic test_empty_store();
    send_request(OP_CLEAR, 32'h0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_CONTAINS, 32'h0);
    send_request(OP_COUNT, 32'h0);
    send_request(OpSpareLast, 32'hFFFF_FFFF);
  endtask

  // fill to capacity, overflow, count an item held in all but one entry, remove with swap
  task automatic test_full_store();
    send_request(OP_ADD, 32'hFFFF_FFFF);
    for (int k = 1; k < Capacity; k++) send_request(OP_ADD, 32'h0);
    send_request(OP_ADD, 32'h5);
    send_request(OP_COUNT, 32'h0);
    send_request(OP_CONTAINS, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OpSpareFirst, 32'h0);
  endtask

  function automatic logic [ItemPortW-1:0] pick_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35 && bag_fill != 0) return bag_entry[$urandom_range(bag_fill - 1)];
    if (r < 75) return item_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  function automatic logic [OpW-1:0] pick_op(input int unsigned add_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < add_pct)      return OP_ADD;
    if (r < add_pct + 20) return OP_REMOVE;
    if (r < add_pct + 28) return OP_CONTAINS;
    if (r < add_pct + 36) return OP_COUNT;
    if (r < add_pct + 38) return OP_CLEAR;
    if (r < add_pct + 40) return OpW'(OpSpareFirst + $urandom_range(2));
    return OP_REMOVE;
  endfunction

  // random requests; add weight swings so the bag sweeps empty to full
  task automatic test_random_traffic(input int unsigned n, input int unsigned send_pct,
                                     input int unsigned stall_pct);
    int unsigned add_pct;
    set_pressure(send_pct, stall_pct);
    item_pool[0] = 32'h0;
    item_pool[1] = 32'hFFFF_FFFF;
    item_pool[2] = $urandom;
    item_pool[3] = $urandom;
    add_pct = 60;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) add_pct = (add_pct == 60) ? 30 : 60;
      send_request(pick_op(add_pct), pick_item());
    end
  endtask

  // fixed limit on the whole run
  initial begin
    #5_000_000;
    $display("fixed_capacity_multiset_store: mismatch");
    $finish;
  end

  initial begin
    bag_fill = 0;
    mismatches = 0;
    requests_sent = 0;
    results_checked = 0;
    full_reached = 0;
    add_rejected = 0;
    set_pressure(0, 0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_full_store();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 64, 0);
    test_random_traffic(240, 0, 64);
    test_random_traffic(240, 15, 15);

    // drain outstanding results, then let the block settle
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("%0d requests, %0d results checked under four idle/stall mixes",
             requests_sent, results_checked);
    $display("store filled %0d times, %0d adds rejected while full",
             full_reached, add_rejected);
    if (mismatches == 0) begin
      $display("fixed_capacity_multiset_store: match");
    end else begin
      $display("fixed_capacity_multiset_store: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fcms_pkg.sv
hw/rtl/fcms_mem.sv
hw/rtl/fcms_ctrl.sv
hw/rtl/fixed_capacity_multiset_store.sv
bench/fixed_capacity_multiset_store_test.sv
